[sv/gai_pkg.sv]
// ----------------------------------------------------------------------------
// gai_pkg
// Shared constants, register codes and the controller command bundle for the
// gyro angle integrator.
// ----------------------------------------------------------------------------
package gai_pkg;

    // calibration and accumulator sizing
    localparam int CAL_SAMPLES = 100;
    localparam int ANGLE_WIDTH = 48;
    localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);

    // field widths
    localparam int RATE_W    = 16;
    localparam int ELAPSED_W = 16;
    localparam int WEIGHT_W  = 9;
    localparam int LIMIT_W   = 47;
    localparam int GAIN_W    = 32;
    localparam int OUT_W     = 16;

    // calibration sum and bias by reciprocal multiply; exact for rounded
    // magnitudes below 2^(CSUM_W-1) and sample counts below 2^7
    localparam int CSUM_W  = 24;
    localparam int DIV_K   = CSUM_W - 1 + 7;
    localparam int RECIP_W = DIV_K + 1;
    localparam int DPROD_W = CSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << DIV_K) + CAL_SAMPLES - 1) / CAL_SAMPLES);

    // Q8 unity for the smoother weight
    localparam int Q8_ONE = 256;

    // output saturation
    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAX = 32768;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_WEIGHT = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd128;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 47'd675521000;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd63580;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cal_acc;
        logic div_init;
        logic div_mul;
        logic div_done;
        logic mul1;
        logic smooth;
        logic mul2;
        logic acc;
        logic abs_mag;
        logic clamp;
        logic map;
        logic out;
    } t_cmd;

endpackage

[sv/gai_ctrl.sv]
// ----------------------------------------------------------------------------
// gai_ctrl
// Sequencer: counts calibration beats, steps the bias reciprocal multiply and
// walks each sample through the datapath phases; owns the output valid flag.
// ----------------------------------------------------------------------------
module gai_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output gai_pkg::t_cmd o_cmd
);
    import gai_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_INIT = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_DIV_DONE = 4'd3;
    localparam logic [3:0] S_MUL1     = 4'd4;
    localparam logic [3:0] S_SMOOTH   = 4'd5;
    localparam logic [3:0] S_MUL2     = 4'd6;
    localparam logic [3:0] S_ACC      = 4'd7;
    localparam logic [3:0] S_ABS      = 4'd8;
    localparam logic [3:0] S_CLAMP    = 4'd9;
    localparam logic [3:0] S_MAP      = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0]           r_state,   n_state;
    logic [CNT_W-1:0]     r_cal_cnt, n_cal_cnt;
    logic                 r_out_valid, n_out_valid;
    t_cmd                 cmd;

    always_comb begin
        n_state   = r_state;
        n_cal_cnt = r_cal_cnt;
        cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    if (r_cal_cnt < CNT_W'(CAL_SAMPLES)) begin
                        cmd.cal_acc = 1'b1;
                        n_cal_cnt   = r_cal_cnt + 1'b1;
                        if (n_cal_cnt == CNT_W'(CAL_SAMPLES)) begin
                            n_state = S_DIV_INIT;
                        end
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_mul = 1'b1;
                n_state     = S_DIV_DONE;
            end
            S_DIV_DONE: begin
                cmd.div_done = 1'b1;
                n_state      = S_IDLE;
            end
            S_MUL1: begin
                cmd.mul1 = 1'b1;
                n_state  = S_SMOOTH;
            end
            S_SMOOTH: begin
                cmd.smooth = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2 = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = S_ABS;
            end
            S_ABS: begin
                cmd.abs_mag = 1'b1;
                n_state     = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                n_state   = S_MAP;
            end
            S_MAP: begin
                cmd.map = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    cmd.out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cal_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cal_cnt   <= n_cal_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[sv/gai_lane.sv]
// ----------------------------------------------------------------------------
// gai_lane
// Datapath for one gyro channel: calibration sum and bias divider, Q8
// smoother, saturating angle accumulator and Q32 output mapping.
// ----------------------------------------------------------------------------
module gai_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gai_pkg::t_cmd                        i_cmd,
    input  logic signed [gai_pkg::RATE_W-1:0]    i_rate,
    input  logic        [gai_pkg::ELAPSED_W-1:0] i_elapsed,
    input  logic        [gai_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic        [gai_pkg::LIMIT_W-1:0]   i_limit,
    input  logic        [gai_pkg::GAIN_W-1:0]    i_gain,
    output logic signed [gai_pkg::OUT_W-1:0]     o_mapped
);
    import gai_pkg::*;

    localparam int AW     = ANGLE_WIDTH;
    localparam int D_W    = RATE_W + 1;
    localparam int SM_W   = 26;
    localparam int P2_W   = WEIGHT_W + 1 + SM_W;
    localparam int PROD_W = SM_W + ELAPSED_W + 1;
    localparam int INC_W  = PROD_W - 8;
    localparam int ASUM_W = ((AW > INC_W) ? AW : INC_W) + 1;
    localparam int CMP_W  = (AW > LIMIT_W) ? AW : LIMIT_W;
    localparam int HI_W   = LIMIT_W - 16;
    localparam int HG_W   = HI_W + GAIN_W;
    localparam int LG_W   = 16 + GAIN_W;
    localparam int Q_W    = 48;

    localparam logic signed [ASUM_W-1:0] AMAX =
        {{(ASUM_W - AW + 1){1'b0}}, {(AW - 1){1'b1}}};
    localparam logic signed [ASUM_W-1:0] AMIN =
        {{(ASUM_W - AW + 1){1'b1}}, {(AW - 1){1'b0}}};

    // calibration and bias
    logic signed [CSUM_W-1:0] r_csum;
    logic        [CSUM_W-1:0] r_dq;
    logic        [DPROD_W-1:0] r_dprod;
    logic                     r_cneg;
    logic signed [RATE_W-1:0] r_bias;

    // sample path
    logic signed [RATE_W-1:0]    r_rate;
    logic        [ELAPSED_W-1:0] r_elapsed;
    logic signed [SM_W-1:0]      r_p1;
    logic signed [P2_W-1:0]      r_p2;
    logic signed [SM_W-1:0]      r_smooth;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [AW-1:0]        r_angle;
    logic                        r_neg;
    logic        [AW-1:0]        r_mag;
    logic        [LIMIT_W-1:0]   r_m;
    logic        [HG_W-1:0]      r_hg;
    logic        [LG_W-1:0]      r_lg;
    logic signed [OUT_W-1:0]     r_out;

    logic        [RATE_W-1:0]    bias_mag;
    logic signed [D_W-1:0]       diff;
    logic        [WEIGHT_W-1:0]  wc;
    logic signed [SM_W:0]        p1_full;
    logic signed [INC_W-1:0]     inc;
    logic signed [ASUM_W-1:0]    asum;
    logic signed [AW-1:0]        n_angle;
    logic        [AW-1:0]        ang_u;
    logic        [LIMIT_W-1:0]   n_m;
    logic        [63:0]          qsum;
    logic        [Q_W-1:0]       q;
    logic signed [OUT_W-1:0]     n_out;

    assign bias_mag = RATE_W'(r_dprod >> DIV_K);
    assign diff     = D_W'(r_rate) - D_W'(r_bias);
    assign wc       = WEIGHT_W'(Q8_ONE) - i_weight;
    assign p1_full  = $signed({1'b0, i_weight}) * diff;
    assign inc      = INC_W'(r_prod >>> 8);
    assign asum     = ASUM_W'(r_angle) + ASUM_W'(inc);
    assign ang_u    = r_angle;

    always_comb begin
        if (asum > AMAX) begin
            n_angle = AW'(AMAX);
        end else if (asum < AMIN) begin
            n_angle = AW'(AMIN);
        end else begin
            n_angle = AW'(asum);
        end
    end

    always_comb begin
        if (CMP_W'(r_mag) > CMP_W'(i_limit)) begin
            n_m = i_limit;
        end else begin
            n_m = LIMIT_W'(r_mag);
        end
    end

    // floor((hi*g + ((lo*g) >> 16)) / 2^16)
    assign qsum = 64'(r_hg) + 64'(r_lg >> 16);
    assign q    = Q_W'(qsum >> 16);

    always_comb begin
        if (r_neg) begin
            if (q > Q_W'(OUT_NEG_MAX)) begin
                n_out = OUT_W'(OUT_NEG_MAX);
            end else begin
                n_out = OUT_W'(~q + 1'b1);
            end
        end else begin
            if (q > Q_W'(OUT_POS_MAX)) begin
                n_out = OUT_W'(OUT_POS_MAX);
            end else begin
                n_out = OUT_W'(q);
            end
        end
    end

    // state that the sample recurrences depend on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum   <= '0;
            r_bias   <= '0;
            r_smooth <= '0;
            r_angle  <= '0;
        end else begin
            if (i_cmd.cal_acc) begin
                r_csum <= r_csum + CSUM_W'(i_rate);
            end
            if (i_cmd.div_done) begin
                r_bias <= r_cneg ? RATE_W'(~bias_mag + 1'b1) : bias_mag;
            end
            if (i_cmd.smooth) begin
                r_smooth <= r_p1 + SM_W'(r_p2 >>> 8);
            end
            if (i_cmd.acc) begin
                r_angle <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate    <= i_rate;
            r_elapsed <= i_elapsed;
        end
        // rounded magnitude |sum| + N/2, then multiply by the scaled 1/N
        if (i_cmd.div_init) begin
            r_cneg <= r_csum[CSUM_W-1];
            if (r_csum[CSUM_W-1]) begin
                r_dq <= ~r_csum + CSUM_W'(CAL_SAMPLES / 2) + 1'b1;
            end else begin
                r_dq <= r_csum + CSUM_W'(CAL_SAMPLES / 2);
            end
        end
        if (i_cmd.div_mul) begin
            r_dprod <= DPROD_W'(r_dq) * DPROD_W'(RECIP);
        end
        if (i_cmd.mul1) begin
            r_p1 <= SM_W'(p1_full);
            r_p2 <= $signed({1'b0, wc}) * r_smooth;
        end
        if (i_cmd.mul2) begin
            r_prod <= r_smooth * $signed({1'b0, r_elapsed});
        end
        if (i_cmd.abs_mag) begin
            r_neg <= ang_u[AW-1];
            r_mag <= ang_u[AW-1] ? (~ang_u + 1'b1) : ang_u;
        end
        if (i_cmd.clamp) begin
            r_m <= n_m;
        end
        if (i_cmd.map) begin
            r_hg <= HG_W'(r_m[LIMIT_W-1:16]) * HG_W'(i_gain);
            r_lg <= LG_W'(r_m[15:0]) * LG_W'(i_gain);
        end
        if (i_cmd.out) begin
            r_out <= n_out;
        end
    end

    assign o_mapped = r_out;

endmodule

[sv/gyro_angle_integrator_top.sv]
// ----------------------------------------------------------------------------
// gyro_angle_integrator_top
// Two-channel gyro rate integrator with start-up bias calibration, Q8
// smoothing, saturating angle accumulation and Q32 output scaling.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  rate_x, rate_y, elapsed_ms
//   m_*       out   m_tvalid/m_tready  mapped_x, mapped_y
//   apb       in    psel/penable       smoothing_weight, angle_limit, map_gain
//
// A calibration beat is accepted straight from idle; the last one then forms
// the bias in the divider states (rounded magnitude, reciprocal multiply, sign).
// A measurement beat walks the multiply, smooth, multiply, accumulate,
// magnitude, clamp, map and output phases before its result shows; the next
// beat is accepted only after the output phase, so beats do not overlap.
// Reset is synchronous and clears calibration, smoother and angle state.
// The next beat is accepted while a result waits; a stalled m_tready holds
// only the final write of the following result.
// ----------------------------------------------------------------------------
module gyro_angle_integrator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // s_tdata: [15:0] rate_x, [31:16] rate_y, [47:32] elapsed_ms
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,
    // m_tdata: [15:0] mapped_x, [31:16] mapped_y
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gai_pkg::ADDR_W-1:0]  paddr,
    input  logic [gai_pkg::DATA_W-1:0]  pwdata,
    output logic [gai_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import gai_pkg::*;

    logic [WEIGHT_W-1:0] r_weight;
    logic [LIMIT_W-1:0]  r_limit;
    logic [GAIN_W-1:0]   r_gain;
    logic [WEIGHT_W-1:0] weight_eff;
    logic [1:0]          reg_idx;
    logic                wr_en;
    t_cmd                cmd;

    logic signed [RATE_W-1:0] mapped_x;
    logic signed [RATE_W-1:0] mapped_y;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RST;
            r_limit  <= LIMIT_RST;
            r_gain   <= GAIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WEIGHT: r_weight <= pwdata[WEIGHT_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WEIGHT: prdata = DATA_W'(r_weight);
            REG_LIMIT:  prdata = DATA_W'(r_limit);
            REG_GAIN:   prdata = DATA_W'(r_gain);
            default:    prdata = '0;
        endcase
    end

    // weights above unity act as unity
    assign weight_eff = (r_weight > WEIGHT_W'(Q8_ONE)) ? WEIGHT_W'(Q8_ONE) : r_weight;

    gai_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_cmd       (cmd)
    );

    gai_lane u_lane_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rate    (s_tdata[15:0]),
        .i_elapsed (s_tdata[47:32]),
        .i_weight  (weight_eff),
        .i_limit   (r_limit),
        .i_gain    (r_gain),
        .o_mapped  (mapped_x)
    );

    gai_lane u_lane_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rate    (s_tdata[31:16]),
        .i_elapsed (s_tdata[47:32]),
        .i_weight  (weight_eff),
        .i_limit   (r_limit),
        .i_gain    (r_gain),
        .o_mapped  (mapped_y)
    );

    assign m_tdata = {mapped_y, mapped_x};

endmodule

[bench/tb_gyro_angle_integrator_top.sv]
// ----------------------------------------------------------------------------
// tb_gyro_angle_integrator_top
// Self-checking bench for the gyro angle integrator. Builds a calibration
// run with known rounding ties, then feeds directed and random rate beats
// under several register settings. A local bit-exact predictor of bias,
// smoother, saturating accumulator and output scaling checks every result.
// Ends with a run of largest-magnitude rates and intervals.
// ----------------------------------------------------------------------------
module tb_gyro_angle_integrator_top;
    import gai_pkg::*;

    localparam int     SETTLE_CYCLES  = 40;    // divider plus pipeline drain
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SAT_BEATS      = 40;
    localparam longint ANG_MAX        = (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1;
    localparam longint ANG_MIN        = -ANG_MAX - 1;

    typedef struct {
        logic [47:0] data;
        bit          drain;    // hold until every pending result is back
    } t_rate_beat;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata  = '0;   // [15:0] rate_x, [31:16] rate_y, [47:32] elapsed_ms
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;         // [15:0] mapped_x, [31:16] mapped_y
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_rate_beat          pending_beats[$];
    logic [31:0]         expected_angles[$];
    int                  fail_count   = 0;
    int                  quiet_cycles = 0;
    bit                  calm         = 1'b0;

    // shadow registers
    logic [WEIGHT_W-1:0] cfg_weight = WEIGHT_RST;
    logic [LIMIT_W-1:0]  cfg_limit  = LIMIT_RST;
    logic [GAIN_W-1:0]   cfg_gain   = GAIN_RST;

    // predicted datapath state
    int                  cal_seen  = 0;
    longint              cal_acc_x = 0;
    longint              cal_acc_y = 0;
    longint              offset_x  = 0;
    longint              offset_y  = 0;
    longint              ema_x     = 0;
    longint              ema_y     = 0;
    longint              ang_x     = 0;
    longint              ang_y     = 0;

    gyro_angle_integrator_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 6);
    endfunction

    // mean of the calibration sum, ties away from zero
    function automatic longint round_mean(input longint sum);
        if (sum >= 0)
            return (sum + CAL_SAMPLES / 2) / CAL_SAMPLES;
        return -((-sum + CAL_SAMPLES / 2) / CAL_SAMPLES);
    endfunction

    function automatic longint sat_add(input longint acc, input longint inc);
        if (inc > 0 && acc > ANG_MAX - inc)
            return ANG_MAX;
        if (inc < 0 && acc < ANG_MIN - inc)
            return ANG_MIN;
        return acc + inc;
    endfunction

    function automatic logic [15:0] scale_angle(input longint ang);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] g;
        logic [63:0] q;
        neg = ang < 0;
        mag = neg ? 64'(-ang) : 64'(ang);
        g   = 64'(cfg_gain);
        if (mag > 64'(cfg_limit))
            mag = 64'(cfg_limit);
        q = ((mag >> 16) * g + (((mag & 64'hFFFF) * g) >> 16)) >> 16;
        if (neg) begin
            if (q > 64'(OUT_NEG_MAX))
                q = 64'(OUT_NEG_MAX);
            return 16'(64'd0 - q);
        end
        if (q > 64'(OUT_POS_MAX))
            q = 64'(OUT_POS_MAX);
        return q[15:0];
    endfunction

    function automatic void integrate_rates(input logic [47:0] beat);
        longint rx;
        longint ry;
        longint el;
        longint w;
        rx = longint'($signed(beat[15:0]));
        ry = longint'($signed(beat[31:16]));
        el = longint'(beat[47:32]);
        if (cal_seen < CAL_SAMPLES) begin
            cal_acc_x += rx;
            cal_acc_y += ry;
            cal_seen++;
            if (cal_seen == CAL_SAMPLES) begin
                offset_x = round_mean(cal_acc_x);
                offset_y = round_mean(cal_acc_y);
            end
            return;
        end
        w     = (cfg_weight > Q8_ONE) ? longint'(Q8_ONE) : longint'(cfg_weight);
        ema_x = (w * (rx - offset_x) * Q8_ONE + (Q8_ONE - w) * ema_x) >>> 8;
        ema_y = (w * (ry - offset_y) * Q8_ONE + (Q8_ONE - w) * ema_y) >>> 8;
        ang_x = sat_add(ang_x, (ema_x * el) >>> 8);
        ang_y = sat_add(ang_y, (ema_y * el) >>> 8);
        expected_angles.push_back({scale_angle(ang_y), scale_angle(ang_x)});
    endfunction

    // driver: one beat in flight on the slave side
    always @(posedge i_clk) begin : drive_rates
        t_rate_beat nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                integrate_rates(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && !take_break() &&
                    !(pending_beats[0].drain &&
                      (s_tvalid || expected_angles.size() != 0))) begin
                    nxt = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : check_angles
        logic [31:0] want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_angles.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_angles.pop_front();
                    if (m_tdata[15:0] !== want[15:0]) begin
                        $error("mapped_x: expected %0d, actual %0d",
                               $signed(want[15:0]), $signed(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== want[31:16]) begin
                        $error("mapped_y: expected %0d, actual %0d",
                               $signed(want[31:16]), $signed(m_tdata[31:16]));
                        fail_count++;
                    end
                end
            end
            m_tready <= !take_break();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WEIGHT: cfg_weight = val[WEIGHT_W-1:0];
            REG_LIMIT:  cfg_limit  = val[LIMIT_W-1:0];
            REG_GAIN:   cfg_gain   = val[GAIN_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic configure(input logic [63:0] w, input logic [63:0] lim,
                             input logic [63:0] g);
        reg_write(REG_WEIGHT, w);
        reg_write(REG_LIMIT, lim);
        reg_write(REG_GAIN, g);
    endtask

    task automatic queue_beat(input logic [15:0] rx, input logic [15:0] ry,
                              input logic [15:0] el, input bit drain = 1'b0);
        t_rate_beat b;
        b.data  = {el, ry, rx};
        b.drain = drain;
        pending_beats.push_back(b);
    endtask

    task automatic queue_random(input int n, input int drain_every = 0);
        int          mode;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] el;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                rx = $urandom;
                ry = $urandom;
            end else begin
                rx = 16'($urandom_range(0, 3000)) - 16'd1200;
                ry = 16'($urandom_range(0, 3000)) - 16'd1800;
            end
            el = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
            queue_beat(rx, ry, el, drain_every != 0 && (i % drain_every) == drain_every - 1);
        end
    endtask

    // sampled at the falling edge so driver and monitor updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || s_tvalid || expected_angles.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        longint      sum_x;
        longint      sum_y;
        logic [15:0] vx;
        logic [15:0] vy;
        sum_x = 0;
        sum_y = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        configure(64'(WEIGHT_RST), 64'(LIMIT_RST), 64'(GAIN_RST));

        // calibration: X sum lands on +...50, Y sum on -...50 (rounding ties)
        for (int i = 0; i < CAL_SAMPLES - 1; i++) begin
            vx = 16'($urandom_range(200, 400));
            vy = 16'(-$urandom_range(200, 400));
            sum_x += longint'($signed(vx));
            sum_y += longint'($signed(vy));
            queue_beat(vx, vy, 16'($urandom));
        end
        vx = 16'(300 + (150 - (sum_x % 100)) % 100);
        vy = 16'(-(300 + (150 - ((-sum_y) % 100)) % 100));
        queue_beat(vx, vy, 16'd0);

        // directed measurement beats
        queue_beat(16'd350, -16'sd250, 16'd10);
        queue_beat(16'h7FFF, 16'h8000, 16'hFFFF);
        queue_beat(16'h8000, 16'h7FFF, 16'hFFFF);
        queue_beat(16'h0000, 16'h0000, 16'h0000);
        queue_beat(16'h7FFF, 16'h7FFF, 16'h0000);
        queue_beat(16'h8000, 16'h8000, 16'h0001);
        queue_beat(16'hFFFF, 16'h0001, 16'hFFFF);
        queue_beat(16'h5555, 16'hAAAA, 16'h5555);
        queue_beat(16'hAAAA, 16'h5555, 16'hAAAA);
        queue_beat(16'h0000, 16'h0000, 16'hFFFF);
        queue_random(150);
        wait_idle();

        // frozen smoother, clamp limit of one, full gain
        configure(64'd0, 64'd1, 64'hFFFF_FFFF);
        queue_beat(16'h7FFF, 16'h8000, 16'hFFFF);
        queue_beat(16'h8000, 16'h7FFF, 16'hFFFF);
        queue_random(150);
        wait_idle();

        // weight above unity; sender drains the pipe now and then
        configure(64'd511, 64'($urandom_range(1, 32'h7FFF_FFFF)), 64'($urandom));
        queue_random(200, 40);
        wait_idle();

        // zero clamp: outputs must read zero
        configure(64'd256, 64'd0, 64'hFFFF_FFFF);
        queue_beat(16'h7FFF, 16'h8000, 16'hFFFF);
        queue_random(50);
        wait_idle();

        configure(64'($urandom_range(0, 511)), {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF,
                  64'd0);
        queue_random(50);
        wait_idle();

        calm = 1'b1;
        configure(64'($urandom_range(0, 511)), {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF,
                  64'($urandom_range(0, 65535)));
        queue_random(200);
        wait_idle();
        calm = 1'b0;

        configure(64'($urandom_range(1, 255)), 64'($urandom_range(1000, 2000000000)),
                  64'($urandom));
        queue_random(150);
        wait_idle();

        // drive at the largest rates and intervals, then reverse
        configure(64'd256, 64'h7FFF_FFFF_FFFF, 64'd1);
        for (int i = 0; i < SAT_BEATS; i++)
            queue_beat(16'h7FFF, 16'h8000, 16'hFFFF);
        for (int i = 0; i < 10; i++)
            queue_beat(16'h8000, 16'h7FFF, 16'hFFFF);
        wait_idle();

        if (fail_count == 0 && expected_angles.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
